### rtl/dssa_pkg.sv
// Shared types and codes for the DMA stream slot allocator.
// Used by every module of the block; depends on nothing else.
package dssa_pkg;

	typedef enum logic [1:0] {
		REQ_ALLOC_SINGLE = 2'd0,
		REQ_ALLOC_CONT   = 2'd1,
		REQ_EVENT        = 2'd2,
		REQ_ABORT        = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_CONT   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_WAIT     = 2'd1,
		ST_NOMATCH  = 2'd2,
		ST_INACTIVE = 2'd3
	} status_t;

	localparam int MASK_W  = 16;
	localparam int INDEX_W = 4;
	localparam int CHAN_W  = 3;

	// One request as held in the input register.
	typedef struct packed {
		req_t                req_type;
		logic [MASK_W-1:0]   stream_mask;
		logic [CHAN_W-1:0]   request_channel;
		logic [INDEX_W-1:0]  stream_index;
		logic                error_flag;
		logic                complete_flag;
		logic                renew_buffer;
	} item_t;

	// One result as held in the output register.
	typedef struct packed {
		status_t             status;
		logic [INDEX_W-1:0]  granted_stream;
		logic [CHAN_W-1:0]   channel_select;
		logic                stream_released;
		logic                finished_buffer;
		logic                report_error;
	} res_t;

	// Write controls for the per-stream state.
	typedef struct packed {
		logic  mode_we;
		mode_t mode;
		logic  tgt_we;
		logic  tgt;
	} upd_t;

endpackage

### rtl/dma_stream_slot_allocator_unit.sv
// DMA stream slot allocator, top level.
// A request in the input register passes the decision logic into the result register.
// Throughput: one request per cycle unless a stalled result blocks it; the per-stream state is read
// and written in the single stage between the input register and the result register.
// Reset (arst_n low) empties both registers and sets every stream idle with target 0.
// Depends on dssa_pkg, dssa_state and dssa_decide.
module dma_stream_slot_allocator_unit #(
	parameter int NUM_STREAMS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [dssa_pkg::MASK_W-1:0]    stream_mask,
	input  logic [dssa_pkg::CHAN_W-1:0]    request_channel,
	input  logic [dssa_pkg::INDEX_W-1:0]   stream_index,
	input  logic                           error_flag,
	input  logic                           complete_flag,
	input  logic                           renew_buffer,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [dssa_pkg::INDEX_W-1:0]   granted_stream,
	output logic [dssa_pkg::CHAN_W-1:0]    channel_select,
	output logic                           stream_released,
	output logic                           finished_buffer,
	output logic                           report_error
);

	localparam int IDX_W = $clog2(NUM_STREAMS);

	logic                              valid_s1;
	dssa_pkg::item_t                   item_s1;
	logic                              out_valid_q;
	dssa_pkg::res_t                    res_q;
	logic                              adv;
	dssa_pkg::res_t                    res;
	dssa_pkg::upd_t                    upd;
	logic [IDX_W-1:0]                  upd_idx;
	dssa_pkg::mode_t [NUM_STREAMS-1:0] modes;
	logic [NUM_STREAMS-1:0]            tgts;

	// The decision stage moves on whenever the result register is free or being taken.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.req_type        <= dssa_pkg::req_t'(req_type);
			item_s1.stream_mask     <= stream_mask;
			item_s1.request_channel <= request_channel;
			item_s1.stream_index    <= stream_index;
			item_s1.error_flag      <= error_flag;
			item_s1.complete_flag   <= complete_flag;
			item_s1.renew_buffer    <= renew_buffer;
		end
	end

	dssa_state #(
		.NUM_STREAMS (NUM_STREAMS),
		.IDX_W       (IDX_W)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.upd_idx (upd_idx),
		.modes   (modes),
		.tgts    (tgts)
	);

	dssa_decide #(
		.NUM_STREAMS (NUM_STREAMS),
		.IDX_W       (IDX_W)
	) u_decide (
		.fire    (valid_s1 && adv),
		.item    (item_s1),
		.modes   (modes),
		.tgts    (tgts),
		.res     (res),
		.upd     (upd),
		.upd_idx (upd_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = res_q.status;
	assign granted_stream  = res_q.granted_stream;
	assign channel_select  = res_q.channel_select;
	assign stream_released = res_q.stream_released;
	assign finished_buffer = res_q.finished_buffer;
	assign report_error    = res_q.report_error;

endmodule

### rtl/dssa_state.sv
// Per-stream mode and current-target registers with a single write port.
// Depends on dssa_pkg for the mode type and the write-control struct.
module dssa_state #(
	parameter int NUM_STREAMS = 16,
	parameter int IDX_W = $clog2(NUM_STREAMS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dssa_pkg::upd_t                        upd,
	input  logic [IDX_W-1:0]                      upd_idx,
	output dssa_pkg::mode_t [NUM_STREAMS-1:0]     modes,
	output logic [NUM_STREAMS-1:0]                tgts
);

	dssa_pkg::mode_t [NUM_STREAMS-1:0] mode_q;
	logic [NUM_STREAMS-1:0]            tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STREAMS; i++) begin
				mode_q[i] <= dssa_pkg::MODE_IDLE;
			end
			tgt_q  <= '0;
		end else begin
			if (upd.mode_we) begin
				mode_q[upd_idx] <= upd.mode;
			end
			if (upd.tgt_we) begin
				tgt_q[upd_idx] <= upd.tgt;
			end
		end
	end

	assign modes = mode_q;
	assign tgts  = tgt_q;

endmodule

### rtl/dssa_decide.sv
// Decision logic: lowest-idle-stream search for allocations and the
// event/abort rules, producing the result and the state write.
// Depends on dssa_pkg.
module dssa_decide #(
	parameter int NUM_STREAMS = 16,
	parameter int IDX_W = $clog2(NUM_STREAMS)
) (
	input  logic                                  fire,
	input  dssa_pkg::item_t                       item,
	input  dssa_pkg::mode_t [NUM_STREAMS-1:0]     modes,
	input  logic [NUM_STREAMS-1:0]                tgts,
	output dssa_pkg::res_t                        res,
	output dssa_pkg::upd_t                        upd,
	output logic [IDX_W-1:0]                      upd_idx
);

	// Only the streams that a 16-bit mask can name take part in a search.
	localparam int NSCAN = (NUM_STREAMS < dssa_pkg::MASK_W) ? NUM_STREAMS : dssa_pkg::MASK_W;

	logic             grant_ok;
	logic             wait_ok;
	logic [IDX_W-1:0] grant_idx;
	logic [IDX_W-1:0] sel;
	logic             in_range;
	dssa_pkg::mode_t  mode_at;
	logic             tgt_at;

	always_comb begin
		grant_ok  = 1'b0;
		wait_ok   = 1'b0;
		grant_idx = '0;
		// Scanning downward leaves the lowest matching stream as the winner.
		for (int i = NSCAN - 1; i >= 0; i--) begin
			if (item.stream_mask[i] && modes[i] == dssa_pkg::MODE_IDLE) begin
				grant_ok  = 1'b1;
				grant_idx = IDX_W'(i);
			end
			if (item.stream_mask[i] && modes[i] == dssa_pkg::MODE_SINGLE) begin
				wait_ok = 1'b1;
			end
		end
	end

	assign sel      = IDX_W'(item.stream_index);
	assign in_range = 32'(item.stream_index) < NUM_STREAMS;
	assign mode_at  = in_range ? modes[sel] : dssa_pkg::MODE_IDLE;
	assign tgt_at   = in_range ? tgts[sel] : 1'b0;

	always_comb begin
		dssa_pkg::upd_t u;
		u       = '0;
		u.mode  = dssa_pkg::MODE_IDLE;
		res     = '0;
		res.status = dssa_pkg::ST_OK;
		upd_idx = sel;
		case (item.req_type)
			dssa_pkg::REQ_ALLOC_SINGLE, dssa_pkg::REQ_ALLOC_CONT: begin
				if (grant_ok) begin
					u.mode_we = 1'b1;
					u.mode    = (item.req_type == dssa_pkg::REQ_ALLOC_SINGLE) ?
					            dssa_pkg::MODE_SINGLE : dssa_pkg::MODE_CONT;
					u.tgt_we  = 1'b1;
					u.tgt     = 1'b0;
					upd_idx   = grant_idx;
					res.granted_stream = dssa_pkg::INDEX_W'(grant_idx);
					res.channel_select = item.request_channel;
				end else if (wait_ok) begin
					res.status = dssa_pkg::ST_WAIT;
				end else begin
					res.status = dssa_pkg::ST_NOMATCH;
				end
			end
			dssa_pkg::REQ_ABORT: begin
				if (mode_at == dssa_pkg::MODE_IDLE) begin
					res.status = dssa_pkg::ST_INACTIVE;
				end else begin
					u.mode_we = 1'b1;
				end
			end
			dssa_pkg::REQ_EVENT: begin
				if (mode_at == dssa_pkg::MODE_IDLE) begin
					res.status = dssa_pkg::ST_INACTIVE;
				end else if (item.error_flag) begin
					u.mode_we           = 1'b1;
					res.stream_released = 1'b1;
					res.report_error    = 1'b1;
				end else if (item.complete_flag) begin
					if (mode_at == dssa_pkg::MODE_SINGLE) begin
						u.mode_we           = 1'b1;
						res.stream_released = 1'b1;
					end else begin
						// Continuous stream: report the buffer that just finished.
						res.finished_buffer = tgt_at;
						if (item.renew_buffer) begin
							u.tgt_we = 1'b1;
							u.tgt    = ~tgt_at;
						end else begin
							u.mode_we           = 1'b1;
							res.stream_released = 1'b1;
						end
					end
				end
			end
			default: begin
				res.status = dssa_pkg::ST_OK;
			end
		endcase
		u.mode_we = u.mode_we & fire;
		u.tgt_we  = u.tgt_we & fire;
		upd = u;
	end

endmodule

### rtl/dssa_checker.sv
// Port-level checks for the DMA stream slot allocator and the bind that attaches them.
// Depends on dssa_pkg and the top level dma_stream_slot_allocator_unit.
module dssa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [dssa_pkg::INDEX_W-1:0] granted_stream,
	input logic [dssa_pkg::CHAN_W-1:0]  channel_select,
	input logic                         stream_released,
	input logic                         finished_buffer,
	input logic                         report_error
);

	// A stalled result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_stream)
		&& $stable(channel_select) && $stable(stream_released)
		&& $stable(finished_buffer) && $stable(report_error))
		else $error("stalled result changed");

	// Only a granted request carries a stream and a channel number.
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dssa_pkg::ST_OK |->
		granted_stream == '0 && channel_select == '0)
		else $error("stream or channel reported without a grant");

	// An error report always frees the stream and never names a finished buffer.
	a_err_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_error |->
		stream_released && !finished_buffer && status == dssa_pkg::ST_OK)
		else $error("error report without a release");

	// Refused requests never touch a stream.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dssa_pkg::ST_OK |->
		!stream_released && !finished_buffer && !report_error)
		else $error("refused request shows an event outcome");

endmodule

bind dma_stream_slot_allocator_unit dssa_checker u_dssa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.granted_stream  (granted_stream),
	.channel_select  (channel_select),
	.stream_released (stream_released),
	.finished_buffer (finished_buffer),
	.report_error    (report_error)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for dma_stream_slot_allocator_unit: a short directed table, then random
// requests, checked against a cycle-free predictor of the stream mode table. Depends on dssa_pkg.
module testbench;

	localparam int STREAMS      = 16;
	localparam int RANDOM_ITEMS = 1330;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_FROM   = 500;
	localparam int QUIET_TO     = 800;
	localparam int DRAIN_AT     = 1000;

	typedef struct packed {
		dssa_pkg::item_t rq;
		logic            fixed;
		dssa_pkg::res_t  want;
	} step_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    req_type;
	logic [dssa_pkg::MASK_W-1:0]   stream_mask;
	logic [dssa_pkg::CHAN_W-1:0]   request_channel;
	logic [dssa_pkg::INDEX_W-1:0]  stream_index;
	logic                          error_flag;
	logic                          complete_flag;
	logic                          renew_buffer;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    status;
	logic [dssa_pkg::INDEX_W-1:0]  granted_stream;
	logic [dssa_pkg::CHAN_W-1:0]   channel_select;
	logic                          stream_released;
	logic                          finished_buffer;
	logic                          report_error;

	// Side payload that travels with each request: a typed-in result for directed rows.
	logic                          row_fixed;
	dssa_pkg::res_t                row_want;

	dssa_pkg::mode_t               shadow_mode [STREAMS];
	logic                          shadow_target [STREAMS];
	dssa_pkg::res_t                pending_outcomes [$];
	int                            fail_count;
	int                            requests_taken;
	int                            results_taken;
	int                            n_grant, n_wait, n_nomatch, n_inactive, n_release, n_swap, n_error;
	step_row_t                     script [23];

	dma_stream_slot_allocator_unit #(.NUM_STREAMS(STREAMS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .stream_mask(stream_mask), .request_channel(request_channel),
		.stream_index(stream_index), .error_flag(error_flag), .complete_flag(complete_flag),
		.renew_buffer(renew_buffer),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .granted_stream(granted_stream), .channel_select(channel_select),
		.stream_released(stream_released), .finished_buffer(finished_buffer),
		.report_error(report_error)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic dssa_pkg::res_t outcome(input dssa_pkg::status_t st, input logic [3:0] g,
		input logic [2:0] c, input logic [2:0] flags);
		dssa_pkg::res_t r;
		r = dssa_pkg::res_t'(0);
		r.status = st;
		r.granted_stream = g;
		r.channel_select = c;
		{r.stream_released, r.finished_buffer, r.report_error} = flags;
		return r;
	endfunction

	function automatic step_row_t row(input dssa_pkg::req_t k, input logic [15:0] m,
		input logic [2:0] c, input logic [3:0] s, input logic [2:0] flags, input logic fixed,
		input dssa_pkg::res_t want);
		step_row_t r;
		r.rq.req_type = k;
		r.rq.stream_mask = m;
		r.rq.request_channel = c;
		r.rq.stream_index = s;
		{r.rq.error_flag, r.rq.complete_flag, r.rq.renew_buffer} = flags;
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	// Applies one request to the shadow mode table and returns the result it must produce.
	function automatic dssa_pkg::res_t allocator_outcome(input dssa_pkg::item_t rq);
		dssa_pkg::res_t r;
		int             pick;
		bit             has_single;
		int             i;
		r = dssa_pkg::res_t'(0);
		r.status = dssa_pkg::ST_OK;
		pick = -1;
		has_single = 0;
		if (rq.req_type == dssa_pkg::REQ_ALLOC_SINGLE || rq.req_type == dssa_pkg::REQ_ALLOC_CONT) begin
			for (i = STREAMS - 1; i >= 0; i--) begin
				if (rq.stream_mask[i] && shadow_mode[i] == dssa_pkg::MODE_IDLE)
					pick = i;
				if (rq.stream_mask[i] && shadow_mode[i] == dssa_pkg::MODE_SINGLE)
					has_single = 1;
			end
			if (pick >= 0) begin
				shadow_mode[pick] = (rq.req_type == dssa_pkg::REQ_ALLOC_SINGLE) ?
					dssa_pkg::MODE_SINGLE : dssa_pkg::MODE_CONT;
				shadow_target[pick] = 1'b0;
				r.granted_stream = 4'(pick);
				r.channel_select = rq.request_channel;
			end else if (has_single) begin
				r.status = dssa_pkg::ST_WAIT;
			end else begin
				r.status = dssa_pkg::ST_NOMATCH;
			end
		end else if (rq.stream_index >= STREAMS
			|| shadow_mode[rq.stream_index] == dssa_pkg::MODE_IDLE) begin
			r.status = dssa_pkg::ST_INACTIVE;
		end else if (rq.req_type == dssa_pkg::REQ_ABORT) begin
			shadow_mode[rq.stream_index] = dssa_pkg::MODE_IDLE;
		end else if (rq.error_flag) begin
			shadow_mode[rq.stream_index] = dssa_pkg::MODE_IDLE;
			r.stream_released = 1'b1;
			r.report_error = 1'b1;
		end else if (rq.complete_flag) begin
			if (shadow_mode[rq.stream_index] == dssa_pkg::MODE_SINGLE) begin
				shadow_mode[rq.stream_index] = dssa_pkg::MODE_IDLE;
				r.stream_released = 1'b1;
			end else begin
				r.finished_buffer = shadow_target[rq.stream_index];
				if (rq.renew_buffer) begin
					shadow_target[rq.stream_index] = ~shadow_target[rq.stream_index];
				end else begin
					shadow_mode[rq.stream_index] = dssa_pkg::MODE_IDLE;
					r.stream_released = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic note_failure(input string what, input dssa_pkg::res_t want,
		input dssa_pkg::res_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%t %s: expected st=%0d g=%0d ch=%0d rel=%0b fin=%0b err=%0b",
				$realtime, what, want.status, want.granted_stream, want.channel_select,
				want.stream_released, want.finished_buffer, want.report_error);
			$display("    got st=%0d g=%0d ch=%0d rel=%0b fin=%0b err=%0b",
				got.status, got.granted_stream, got.channel_select,
				got.stream_released, got.finished_buffer, got.report_error);
		end
	endtask

	// Result checking first, then prediction of the request taken at the same edge.
	always @(posedge clk) begin
		dssa_pkg::res_t  got;
		dssa_pkg::res_t  want;
		dssa_pkg::item_t rq;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = dssa_pkg::res_t'(0);
				got.status = dssa_pkg::status_t'(status);
				got.granted_stream = granted_stream;
				got.channel_select = channel_select;
				got.stream_released = stream_released;
				got.finished_buffer = finished_buffer;
				got.report_error = report_error;
				results_taken <= results_taken + 1;
				if (pending_outcomes.size() == 0) begin
					note_failure("unexpected result", dssa_pkg::res_t'(0), got);
				end else begin
					want = pending_outcomes.pop_front();
					if (got.status !== want.status || got.granted_stream !== want.granted_stream
						|| got.channel_select !== want.channel_select
						|| got.stream_released !== want.stream_released
						|| got.finished_buffer !== want.finished_buffer
						|| got.report_error !== want.report_error)
						note_failure("result mismatch", want, got);
				end
			end
			if (in_valid && !in_stall) begin
				rq.req_type = dssa_pkg::req_t'(req_type);
				rq.stream_mask = stream_mask;
				rq.request_channel = request_channel;
				rq.stream_index = stream_index;
				rq.error_flag = error_flag;
				rq.complete_flag = complete_flag;
				rq.renew_buffer = renew_buffer;
				want = allocator_outcome(rq);
				case (want.status)
					dssa_pkg::ST_OK: begin
						if (rq.req_type == dssa_pkg::REQ_ALLOC_SINGLE
							|| rq.req_type == dssa_pkg::REQ_ALLOC_CONT)
							n_grant++;
					end
					dssa_pkg::ST_WAIT: n_wait++;
					dssa_pkg::ST_NOMATCH: n_nomatch++;
					default: n_inactive++;
				endcase
				if (want.stream_released) n_release++;
				if (want.report_error) n_error++;
				if (rq.req_type == dssa_pkg::REQ_EVENT && want.status == dssa_pkg::ST_OK
					&& rq.complete_flag && !rq.error_flag && !want.stream_released
					&& rq.renew_buffer)
					n_swap++;
				pending_outcomes.push_back(row_fixed ? row_want : want);
				requests_taken <= requests_taken + 1;
			end
		end
	end

	// Result side: random stalls, one long hold-off and a quiet window.
	initial begin
		int  hold_left;
		bit  hold_done;
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && requests_taken >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (requests_taken >= QUIET_FROM && requests_taken < QUIET_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 11);
			end
		end
	end

	task automatic pause_requests(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic offer(input dssa_pkg::item_t rq, input logic fixed, input dssa_pkg::res_t want);
		in_valid <= 1'b1;
		req_type <= rq.req_type;
		stream_mask <= rq.stream_mask;
		request_channel <= rq.request_channel;
		stream_index <= rq.stream_index;
		error_flag <= rq.error_flag;
		complete_flag <= rq.complete_flag;
		renew_buffer <= rq.renew_buffer;
		row_fixed <= fixed;
		row_want <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	initial begin
		dssa_pkg::item_t rq;
		int              n;
		int              group;
		int              pick;
		bit              quiet;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = dssa_pkg::REQ_ALLOC_SINGLE;
		stream_mask = '0;
		request_channel = '0;
		stream_index = '0;
		error_flag = 1'b0;
		complete_flag = 1'b0;
		renew_buffer = 1'b0;
		row_fixed = 1'b0;
		row_want = dssa_pkg::res_t'(0);
		fail_count = 0;
		requests_taken = 0;
		results_taken = 0;
		{n_grant, n_wait, n_nomatch, n_inactive, n_release, n_swap, n_error} = '0;
		for (n = 0; n < STREAMS; n++) begin
			shadow_mode[n] = dssa_pkg::MODE_IDLE;
			shadow_target[n] = 1'b0;
		end

		// Directed walk from reset; flags are {error, complete, renew} on the request
		// and {released, finished, error} on the result.
		script[0]  = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd0, 3'b010, 1,
			outcome(dssa_pkg::ST_INACTIVE, 4'd0, 3'd0, 3'b000));
		script[1]  = row(dssa_pkg::REQ_ABORT, 16'hFFFF, 3'd7, 4'd15, 3'b111, 1,
			outcome(dssa_pkg::ST_INACTIVE, 4'd0, 3'd0, 3'b000));
		script[2]  = row(dssa_pkg::REQ_ALLOC_SINGLE, 16'h0000, 3'd7, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_NOMATCH, 4'd0, 3'd0, 3'b000));
		script[3]  = row(dssa_pkg::REQ_ALLOC_SINGLE, 16'h8000, 3'd7, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_OK, 4'd15, 3'd7, 3'b000));
		script[4]  = row(dssa_pkg::REQ_ALLOC_CONT, 16'h8000, 3'd4, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_WAIT, 4'd0, 3'd0, 3'b000));
		script[5]  = row(dssa_pkg::REQ_ALLOC_CONT, 16'h0001, 3'd5, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd5, 3'b000));
		script[6]  = row(dssa_pkg::REQ_ALLOC_SINGLE, 16'h0001, 3'd1, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_NOMATCH, 4'd0, 3'd0, 3'b000));
		script[7]  = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd0, 3'b011, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b000));
		script[8]  = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd0, 3'b011, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b010));
		script[9]  = row(dssa_pkg::REQ_EVENT, 16'hFFFF, 3'd7, 4'd0, 3'b001, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b000));
		script[10] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd0, 3'b010, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b100));
		script[11] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd15, 3'b011, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b100));
		script[12] = row(dssa_pkg::REQ_ALLOC_SINGLE, 16'hFFFF, 3'd0, 4'd0, 3'b000, 0,
			dssa_pkg::res_t'(0));
		script[13] = row(dssa_pkg::REQ_ALLOC_CONT, 16'hFFFF, 3'd2, 4'd15, 3'b111, 0,
			dssa_pkg::res_t'(0));
		script[14] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd1, 3'b111, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b101));
		script[15] = row(dssa_pkg::REQ_ABORT, 16'h0000, 3'd0, 4'd0, 3'b000, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b000));
		script[16] = row(dssa_pkg::REQ_ALLOC_SINGLE, 16'hFFFF, 3'd3, 4'd0, 3'b000, 0,
			dssa_pkg::res_t'(0));
		script[17] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd0, 3'b100, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b101));
		script[18] = row(dssa_pkg::REQ_ALLOC_CONT, 16'h0006, 3'd6, 4'd0, 3'b000, 0,
			dssa_pkg::res_t'(0));
		script[19] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd1, 3'b011, 0,
			dssa_pkg::res_t'(0));
		script[20] = row(dssa_pkg::REQ_ABORT, 16'h0000, 3'd0, 4'd1, 3'b011, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b000));
		script[21] = row(dssa_pkg::REQ_ALLOC_CONT, 16'hAAAA, 3'd1, 4'd0, 3'b000, 0,
			dssa_pkg::res_t'(0));
		// The grant must have cleared the target that the earlier renewal toggled.
		script[22] = row(dssa_pkg::REQ_EVENT, 16'h0000, 3'd0, 4'd1, 3'b010, 1,
			outcome(dssa_pkg::ST_OK, 4'd0, 3'd0, 3'b100));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < 23; n++) begin
			if ($urandom_range(99) < 11)
				pause_requests($urandom_range(1, 3));
			offer(script[n].rq, script[n].fixed, script[n].want);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= QUIET_FROM && n < QUIET_TO);
			if (n == DRAIN_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_outcomes.size() != 0) @(posedge clk);
			end else if (!quiet && $urandom_range(99) < 11) begin
				pause_requests($urandom_range(1, 4));
			end
			rq = dssa_pkg::item_t'(0);
			pick = $urandom_range(99);
			if (pick < 22)
				rq.req_type = dssa_pkg::REQ_ALLOC_SINGLE;
			else if (pick < 40)
				rq.req_type = dssa_pkg::REQ_ALLOC_CONT;
			else if (pick < 85)
				rq.req_type = dssa_pkg::REQ_EVENT;
			else
				rq.req_type = dssa_pkg::REQ_ABORT;
			// Most requests stay inside one group of four streams so that groups fill up
			// and events keep hitting active streams; the rest are spread over all sixteen.
			group = $urandom_range(3) * 4;
			if ($urandom_range(99) < 75) begin
				rq.stream_mask = 16'($urandom_range(15) << group);
				rq.stream_index = 4'(group + $urandom_range(3));
			end else begin
				rq.stream_mask = 16'($urandom);
				rq.stream_index = 4'($urandom);
			end
			rq.request_channel = 3'($urandom);
			rq.error_flag = ($urandom_range(99) < 12);
			rq.complete_flag = ($urandom_range(99) < 65);
			rq.renew_buffer = 1'($urandom);
			offer(rq, 1'b0, dssa_pkg::res_t'(0));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (pending_outcomes.size() != 0)
			note_failure("result never arrived", pending_outcomes[0], dssa_pkg::res_t'(0));

		$display("Covered %0d requests and %0d results: %0d grants, %0d wait,",
			requests_taken, results_taken, n_grant, n_wait);
		$display("%0d no match, %0d not active; streams freed %0d times (%0d on error),",
			n_nomatch, n_inactive, n_release, n_error);
		$display("%0d buffer swaps; %0d failures.", n_swap, fail_count);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
